// File: design/fcwc_pkg.sv
// ----------------------------------------------------------------------------
// fcwc_pkg: shared types and constants of the congestion window controller
// Item formats, per-flow table layout and event codes.
// ----------------------------------------------------------------------------
package fcwc_pkg;

  localparam int unsigned FLOWS   = 16;
  localparam int unsigned FLOW_AW = (FLOWS > 1) ? $clog2(FLOWS) : 1;

  localparam int unsigned ID_W  = 32;
  localparam int unsigned OOO_W = 2;

  localparam logic [ID_W-1:0]  WIN_MAX    = '1;
  localparam logic [ID_W-1:0]  WIN_RESET  = ID_W'(1);
  localparam logic [OOO_W-1:0] OOO_LIMIT  = OOO_W'(3);

  // Event codes carried in the func field.
  typedef enum logic {
    FUNC_SEND = 1'b0,
    FUNC_ACK  = 1'b1
  } func_t;

  typedef struct packed {
    logic            func;
    logic [3:0]      flow_id;
    logic [ID_W-1:0] ack_packet_id;
    logic            queue_full;
  } in_item_t;

  typedef struct packed {
    logic            sent;
    logic [ID_W-1:0] sent_packet_id;
    logic            dropped;
    logic [ID_W-1:0] window;
    logic [ID_W-1:0] acked_upto;
  } out_item_t;

  // One entry of the per-flow table.
  typedef struct packed {
    logic [ID_W-1:0]  window_size;
    logic [ID_W-1:0]  highest_sent;
    logic [ID_W-1:0]  highest_acked;
    logic [OOO_W-1:0] out_of_order_count;
    logic             resend_pending;
  } flow_entry_t;

  localparam flow_entry_t ENTRY_RESET = '{
    window_size:        WIN_RESET,
    highest_sent:       '0,
    highest_acked:      '0,
    out_of_order_count: '0,
    resend_pending:     1'b0
  };

endpackage

// File: design/flow_congestion_window_control_core.sv
// ----------------------------------------------------------------------------
// flow_congestion_window_control_core: per-flow AIMD congestion window control
// Keeps the window and packet id state of every flow in one table memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_stall/in_data. A send request issues the
//   next packet id of its flow when the window allows it; an ack request
//   advances the acked id and grows the window, or counts an out-of-order
//   arrival and halves the window on every fourth such arrival.
//   Every request yields exactly one result on out_valid/out_stall/out_data.
//   Each request passes the update stage and then the output register before
//   its result is valid. The table memory is read in the cycle the request is
//   taken and written when the request leaves the update stage; a request to
//   the flow written just before gets the new entry through a bypass register,
//   so one request per cycle is sustained while out_stall is low.
//   When out_stall holds the output register full, the request in the update
//   stage waits and in_stall rises; nothing is lost or repeated.
//   Reset clears the entry valid bits at once, so every flow reads as
//   window 1 with all ids zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module flow_congestion_window_control_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fcwc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fcwc_pkg::out_item_t out_data
);
  import fcwc_pkg::*;

  // Table memory with per-entry valid bits.
  flow_entry_t        mem [FLOWS];
  logic [FLOWS-1:0]   ent_valid_r;

  logic               in_acc;
  logic [FLOW_AW-1:0] in_idx;

  // Update stage.
  logic               b_valid_r;
  in_item_t           b_item_r;
  flow_entry_t        rd_data_r;
  logic               rd_valid_r;
  logic               b_adv;
  logic               b_in_range;
  logic [FLOW_AW-1:0] b_idx;

  // Bypass of the last write.
  logic               wb_valid_r;
  logic               wb_valid_nxt;
  logic [FLOW_AW-1:0] wb_idx_r;
  flow_entry_t        wb_data_r;

  flow_entry_t        cur;
  flow_entry_t        upd;
  out_item_t          res;
  logic [ID_W-1:0]    hs;
  logic               may_send;

  out_item_t          out_data_r;
  logic               out_valid_r;

  assign in_idx     = FLOW_AW'(in_data.flow_id);
  assign b_idx      = FLOW_AW'(b_item_r.flow_id);
  assign b_in_range = (32'(b_item_r.flow_id) < FLOWS);

  assign b_adv    = b_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = b_valid_r && !b_adv;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Current entry: bypassed write, stored entry, or reset value.
  always_comb begin
    priority if (wb_valid_r && (wb_idx_r == b_idx)) begin
      cur = wb_data_r;
    end else if (rd_valid_r) begin
      cur = rd_data_r;
    end else begin
      cur = ENTRY_RESET;
    end
  end

  always_comb begin
    upd      = cur;
    res      = '0;
    hs       = cur.resend_pending ? cur.highest_acked : cur.highest_sent;
    may_send = (cur.highest_acked > hs) ||
               ((hs - cur.highest_acked) < cur.window_size);
    unique case (func_t'(b_item_r.func))
      FUNC_SEND: begin
        upd.highest_sent   = hs;
        upd.resend_pending = 1'b0;
        if (may_send) begin
          upd.highest_sent   = hs + ID_W'(1);
          res.sent           = 1'b1;
          res.sent_packet_id = hs + ID_W'(1);
          if (b_item_r.queue_full) begin
            res.dropped     = 1'b1;
            upd.window_size = WIN_RESET;
          end
        end
      end
      FUNC_ACK: begin
        if (b_item_r.ack_packet_id == cur.highest_acked + ID_W'(1)) begin
          upd.highest_acked = b_item_r.ack_packet_id;
          if (cur.window_size != WIN_MAX) begin
            upd.window_size = cur.window_size + ID_W'(1);
          end
        end else if (cur.out_of_order_count == OOO_LIMIT) begin
          upd.resend_pending     = 1'b1;
          upd.window_size        = cur.window_size >> 1;
          upd.out_of_order_count = '0;
        end else begin
          upd.out_of_order_count = cur.out_of_order_count + OOO_W'(1);
        end
      end
      default: begin
        upd = cur;
      end
    endcase
    res.window     = upd.window_size;
    res.acked_upto = upd.highest_acked;
    if (!b_in_range) begin
      res = '0;
    end
  end

  // The bypass stays armed while the following request waits in the stage.
  always_comb begin
    if (b_adv) begin
      wb_valid_nxt = b_in_range;
    end else if (b_valid_r) begin
      wb_valid_nxt = wb_valid_r;
    end else begin
      wb_valid_nxt = 1'b0;
    end
  end

  // Memory: one read port taken with the request, one write port.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= mem[in_idx];
    end
    if (b_adv && b_in_range) begin
      mem[b_idx] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
      rd_valid_r  <= 1'b0;
      b_valid_r   <= 1'b0;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_valid_r <= ent_valid_r[in_idx];
      end
      if (b_adv && b_in_range) begin
        ent_valid_r[b_idx] <= 1'b1;
      end
      if (in_acc) begin
        b_valid_r <= 1'b1;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      wb_valid_r <= wb_valid_nxt;
      if (b_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_item_r <= in_data;
    end
    if (b_adv) begin
      wb_idx_r   <= b_idx;
      wb_data_r  <= upd;
      out_data_r <= res;
    end
  end

  a_drop_needs_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.dropped || out_data_r.sent))
    else $error("dropped result without an issued packet");

  a_id_zero_unsent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.sent) |-> (out_data_r.sent_packet_id == '0))
    else $error("packet id set on a result that issued nothing");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> b_valid_r)
    else $error("accepted request did not reach the update stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_adv) |=> (b_valid_r && $stable(b_item_r)))
    else $error("waiting request changed in the update stage");

  a_no_write_unread: assert property (@(posedge clk) disable iff (!rst_n)
    b_adv |-> b_valid_r && (!out_valid_r || !out_stall))
    else $error("table written without a request in the update stage");

endmodule
